@@ rtl/fmd_pkg.sv @@
// Package for the stop-bit message decoder: the result record and shared constants.
// Used by the parser, the result queue and the top level; depends on nothing.
package fmd_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam int unsigned HEADER_BYTES = 10;
    localparam int unsigned PRESENCE_TEMPLATE_BIT = 6;
    localparam int unsigned STOP_BIT = 7;

    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_MAP      = 3'd1;
    localparam logic [2:0] KIND_TEMPLATE = 3'd2;
    localparam logic [2:0] KIND_SEQUENCE = 3'd3;
    localparam logic [2:0] KIND_RAW      = 3'd4;

    localparam logic [1:0] REG_TEMPLATE_FIRST  = 2'd0;
    localparam logic [1:0] REG_TEMPLATE_SECOND = 2'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [15:0] chunk_count;
        logic [15:0] chunk_number;
        logic [15:0] body_length;
        logic        flag;
        logic [15:0] field_number;
        logic [7:0]  raw_byte;
        logic        last_of_field;
    } t_result;

endpackage

@@ rtl/fmd_parse.sv @@
// Front part: parses one stream byte per cycle and builds at most one result beat.
// Depends on fmd_pkg for the result record and the header and kind constants.
module fmd_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic [15:0]     i_tmpl_first,
    input  logic [15:0]     i_tmpl_second,
    output logic            o_res_valid,
    output fmd_pkg::t_result o_res
);
    import fmd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PRELUDE,
        PH_TEMPLATE,
        PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_seq, n_seq;
    logic [15:0] r_cc, n_cc;
    logic [15:0] r_cn, n_cn;
    logic [15:0] r_left, n_left;
    logic [15:0] r_fields, n_fields;
    logic [31:0] r_gather, n_gather;

    logic        stop;
    logic [31:0] gather_next;
    logic [15:0] fields_inc;
    logic [15:0] left_new;
    logic [15:0] tmpl_id;
    logic        tmpl_known;

    assign stop        = i_byte[STOP_BIT];
    assign gather_next = {r_gather[24:0], i_byte[6:0]};
    assign fields_inc  = (r_fields == 16'hFFFF) ? r_fields : r_fields + 16'd1;
    assign left_new    = r_left - 16'd1;
    assign tmpl_id     = gather_next[15:0];
    assign tmpl_known  = (tmpl_id != 16'd0)
                         && ((tmpl_id == i_tmpl_first) || (tmpl_id == i_tmpl_second));

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_seq       = r_seq;
        n_cc        = r_cc;
        n_cn        = r_cn;
        n_left      = r_left;
        n_fields    = r_fields;
        n_gather    = r_gather;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_valid) begin
            if (r_phase == PH_HEADER) begin
                if (r_pos < 4'd4) begin
                    n_seq = {r_seq[23:0], i_byte};
                end else if (r_pos < 4'd6) begin
                    n_cc = {r_cc[7:0], i_byte};
                end else if (r_pos < 4'd8) begin
                    n_cn = {r_cn[7:0], i_byte};
                end else begin
                    n_left = {r_left[7:0], i_byte};
                end
                if ({1'b0, r_pos} + 5'd1 >= 5'(HEADER_BYTES)) begin
                    n_pos              = '0;
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_HEADER;
                    o_res.value        = r_seq;
                    o_res.chunk_count  = r_cc;
                    o_res.chunk_number = r_cn;
                    o_res.body_length  = n_left;
                    n_fields           = '0;
                    n_gather           = '0;
                    n_phase            = (n_left == 16'd0) ? PH_HEADER : PH_PRELUDE;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end else begin
                case (r_phase)
                    PH_PRELUDE: begin
                        n_gather = gather_next;
                        if (stop) begin
                            n_fields     = fields_inc;
                            o_res_valid  = 1'b1;
                            if (fields_inc == 16'd1) begin
                                o_res.kind         = KIND_MAP;
                                o_res.value        = gather_next;
                                o_res.flag         = gather_next[PRESENCE_TEMPLATE_BIT];
                                o_res.field_number = 16'd1;
                                if (!gather_next[PRESENCE_TEMPLATE_BIT]) begin
                                    n_phase = PH_SKIP;
                                end
                            end else begin
                                o_res.kind         = KIND_TEMPLATE;
                                o_res.value        = {16'd0, tmpl_id};
                                o_res.flag         = tmpl_known;
                                o_res.field_number = fields_inc;
                                n_phase            = tmpl_known ? PH_TEMPLATE : PH_SKIP;
                            end
                            n_gather = '0;
                        end
                    end
                    PH_TEMPLATE: begin
                        if (r_fields == 16'd2) begin
                            n_gather = gather_next;
                            if (stop) begin
                                o_res_valid        = 1'b1;
                                o_res.kind         = KIND_SEQUENCE;
                                o_res.value        = gather_next;
                                o_res.field_number = fields_inc;
                                n_gather           = '0;
                                n_fields           = fields_inc;
                            end
                        end else begin
                            o_res_valid         = 1'b1;
                            o_res.kind          = KIND_RAW;
                            o_res.field_number  = fields_inc;
                            o_res.raw_byte      = i_byte;
                            o_res.last_of_field = stop;
                            if (stop) begin
                                n_fields = fields_inc;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                n_left = left_new;
                if (left_new == 16'd0) begin
                    n_phase  = PH_HEADER;
                    n_pos    = '0;
                    n_gather = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= '0;
            r_seq    <= '0;
            r_cc     <= '0;
            r_cn     <= '0;
            r_left   <= '0;
            r_fields <= '0;
            r_gather <= '0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_seq    <= n_seq;
            r_cc     <= n_cc;
            r_cn     <= n_cn;
            r_left   <= n_left;
            r_fields <= n_fields;
            r_gather <= n_gather;
        end
    end

endmodule

@@ rtl/fmd_fifo.sv @@
// Back part: a short queue of result beats that presents the oldest one to the consumer.
// Depends on fmd_pkg for the result record.
module fmd_fifo #(
    parameter int DEPTH = fmd_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  fmd_pkg::t_result i_wr_data,
    input  logic             i_rd,
    output fmd_pkg::t_result o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    import fmd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           wr_go;
    logic           rd_go;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign wr_go     = i_wr && !o_full;
    assign rd_go     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + CW'(1);
        end else if (rd_go && !wr_go) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/fast_stop_bit_message_decoder_top.sv @@
// Top level of the stop-bit message decoder: configuration registers, parser and result queue.
// Depends on fmd_pkg, fmd_parse and fmd_fifo.
// A result beat, if any, is built combinationally and written into the queue by the edge that accepts its byte.
// Throughput is one byte per cycle while full is low, set by the parser; the result queue of
// FIFO_DEPTH beats absorbs consumer stalls, and full is raised while it has no room.
// Synchronous active-low reset clears parser and queue and sets the templates to 144 and 145.
module fast_stop_bit_message_decoder_top #(
    parameter int FIFO_DEPTH = fmd_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [31:0] o_value,
    output logic [15:0] o_chunk_count,
    output logic [15:0] o_chunk_number,
    output logic [15:0] o_body_length,
    output logic        o_flag,
    output logic [15:0] o_field_number,
    output logic [7:0]  o_raw_byte,
    output logic        o_last_of_field,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fmd_pkg::*;

    logic [15:0] r_tmpl_first;
    logic [15:0] r_tmpl_second;
    logic        cfg_wr;
    logic        in_go;
    logic        res_valid;
    t_result     res;
    t_result     head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_TEMPLATE_SECOND[0]) ? {16'd0, r_tmpl_second}
                                                         : {16'd0, r_tmpl_first};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmpl_first  <= 16'd144;
            r_tmpl_second <= 16'd145;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TEMPLATE_FIRST[0]) begin
                r_tmpl_first <= pwdata[15:0];
            end else begin
                r_tmpl_second <= pwdata[15:0];
            end
        end
    end

    assign in_go = push && !full;

    fmd_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_go),
        .i_byte        (i_data_byte),
        .i_tmpl_first  (r_tmpl_first),
        .i_tmpl_second (r_tmpl_second),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    fmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_valid),
        .i_wr_data (res),
        .i_rd      (pop),
        .o_rd_data (head),
        .o_full    (full),
        .o_empty   (empty)
    );

    assign o_kind          = head.kind;
    assign o_value         = head.value;
    assign o_chunk_count   = head.chunk_count;
    assign o_chunk_number  = head.chunk_number;
    assign o_body_length   = head.body_length;
    assign o_flag          = head.flag;
    assign o_field_number  = head.field_number;
    assign o_raw_byte      = head.raw_byte;
    assign o_last_of_field = head.last_of_field;

endmodule

@@ tb/tb_fast_stop_bit_message_decoder_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the stop-bit message decoder: directed table, then random messages.
// Holds its own model of the parser and template registers; depends on fmd_pkg and the top level.
module tb_fast_stop_bit_message_decoder_top;
    import fmd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned PHASE_BYTES = 270;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PRELUDE,
        PH_TEMPLATE,
        PH_SKIP
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        t_result    want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_data_byte;
    logic        empty;
    logic        pop;
    logic [2:0]  o_kind;
    logic [31:0] o_value;
    logic [15:0] o_chunk_count;
    logic [15:0] o_chunk_number;
    logic [15:0] o_body_length;
    logic        o_flag;
    logic [15:0] o_field_number;
    logic [7:0]  o_raw_byte;
    logic        o_last_of_field;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    t_parse_phase parse_phase = PH_HEADER;
    logic [3:0]   hdr_pos = '0;
    logic [31:0]  seq_acc = '0;
    logic [15:0]  count_acc = '0;
    logic [15:0]  number_acc = '0;
    logic [15:0]  bytes_left = '0;
    logic [15:0]  fields_seen = '0;
    logic [31:0]  value_acc = '0;
    logic         tmpl_present = 1'b0;
    logic [15:0]  tmpl_first = 16'd144;
    logic [15:0]  tmpl_second = 16'd145;

    t_result     pending_results [$];
    logic [7:0]  msg_bytes [$];
    int unsigned mismatches = 0;
    int unsigned stream_bytes = 0;
    int unsigned cycle_count = 0;
    bit          src_quiet = 1'b0;
    bit          sink_quiet = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;

    fast_stop_bit_message_decoder_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_data_byte     (i_data_byte),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_value         (o_value),
        .o_chunk_count   (o_chunk_count),
        .o_chunk_number  (o_chunk_number),
        .o_body_length   (o_body_length),
        .o_flag          (o_flag),
        .o_field_number  (o_field_number),
        .o_raw_byte      (o_raw_byte),
        .o_last_of_field (o_last_of_field),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    function automatic t_result mk_res(input logic [2:0] kind, input logic [31:0] value,
                                       input logic [15:0] cc, input logic [15:0] cn,
                                       input logic [15:0] bl, input logic flag,
                                       input logic [15:0] fnum, input logic [7:0] raw,
                                       input logic last);
        t_result r;
        r.kind          = kind;
        r.value         = value;
        r.chunk_count   = cc;
        r.chunk_number  = cn;
        r.body_length   = bl;
        r.flag          = flag;
        r.field_number  = fnum;
        r.raw_byte      = raw;
        r.last_of_field = last;
        return r;
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic int unsigned groups_for(input logic [31:0] v);
        int unsigned n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0) n++;
        return n;
    endfunction

    task automatic decode_byte(input logic [7:0] b, output bit got, output t_result res);
        logic        stop;
        logic [15:0] cur;
        logic [15:0] id;
        logic        known;
        stop = b[STOP_BIT];
        got = 1'b0;
        res = '0;
        if (parse_phase == PH_HEADER) begin
            if (hdr_pos < 4) begin
                seq_acc = {seq_acc[23:0], b};
            end else if (hdr_pos < 6) begin
                count_acc = {count_acc[7:0], b};
            end else if (hdr_pos < 8) begin
                number_acc = {number_acc[7:0], b};
            end else begin
                bytes_left = {bytes_left[7:0], b};
            end
            if (hdr_pos == 4'(HEADER_BYTES - 1)) begin
                hdr_pos = '0;
                res = mk_res(KIND_HEADER, seq_acc, count_acc, number_acc, bytes_left,
                             '0, '0, '0, '0);
                got = 1'b1;
                fields_seen = '0;
                value_acc = '0;
                tmpl_present = 1'b0;
                parse_phase = (bytes_left == 0) ? PH_HEADER : PH_PRELUDE;
            end else begin
                hdr_pos = hdr_pos + 4'd1;
            end
        end else begin
            if (parse_phase == PH_PRELUDE) begin
                value_acc = {value_acc[24:0], b[6:0]};
                if (stop) begin
                    fields_seen = bump(fields_seen);
                    if (fields_seen == 16'd1) begin
                        tmpl_present = value_acc[PRESENCE_TEMPLATE_BIT];
                        res = mk_res(KIND_MAP, value_acc, '0, '0, '0, tmpl_present, 16'd1,
                                     '0, '0);
                        got = 1'b1;
                        if (!tmpl_present) parse_phase = PH_SKIP;
                    end else begin
                        id = value_acc[15:0];
                        known = (id != 0) && (id == tmpl_first || id == tmpl_second);
                        res = mk_res(KIND_TEMPLATE, {16'd0, id}, '0, '0, '0, known,
                                     fields_seen, '0, '0);
                        got = 1'b1;
                        parse_phase = known ? PH_TEMPLATE : PH_SKIP;
                    end
                    value_acc = '0;
                end
            end else if (parse_phase == PH_TEMPLATE) begin
                cur = bump(fields_seen);
                if (fields_seen == 16'd2) begin
                    value_acc = {value_acc[24:0], b[6:0]};
                    if (stop) begin
                        res = mk_res(KIND_SEQUENCE, value_acc, '0, '0, '0, '0, cur, '0, '0);
                        got = 1'b1;
                        value_acc = '0;
                        fields_seen = cur;
                    end
                end else begin
                    res = mk_res(KIND_RAW, '0, '0, '0, '0, '0, cur, b, stop);
                    got = 1'b1;
                    if (stop) fields_seen = cur;
                end
            end
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 0) begin
                parse_phase = PH_HEADER;
                hdr_pos = '0;
                value_acc = '0;
            end
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed, input t_result want);
        bit      got;
        t_result res;
        while (!src_quiet && $urandom_range(99) < 34) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        decode_byte(b, got, res);
        if (got) pending_results.push_back(typed ? want : res);
        stream_bytes++;
        @(negedge i_clk);
    endtask

    task automatic send_header(input logic [15:0] blen);
        logic [79:0] hdr;
        int unsigned k;
        hdr = {32'($urandom), 16'($urandom), 16'($urandom), blen};
        for (k = 0; k < HEADER_BYTES; k++) send_byte(hdr[79 - 8 * k -: 8], 1'b0, '0);
    endtask

    task automatic add_field(input logic [31:0] v, input int unsigned groups);
        int          g;
        logic [31:0] grp;
        for (g = int'(groups) - 1; g >= 0; g--) begin
            grp = (g * 7 < 32) ? (v >> (g * 7)) : 32'd0;
            msg_bytes.push_back({g == 0, grp[6:0]});
        end
    endtask

    task automatic send_random_message();
        int unsigned pick;
        int unsigned sel;
        int unsigned n;
        int unsigned k;
        logic [31:0] v;
        logic [15:0] blen;
        msg_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 78) begin
            v = $urandom;
            v[PRESENCE_TEMPLATE_BIT] = (pick < 70);
            add_field(v, $urandom_range(1, 3));
            if (pick < 70) begin
                sel = $urandom_range(9);
                if (sel < 4) v = {16'd0, tmpl_first};
                else if (sel < 7) v = {16'd0, tmpl_second};
                else if (sel == 7) v = $urandom_range(65535);
                else if (sel == 8) v = '0;
                else v = {16'($urandom_range(1, 65535)), tmpl_first};
                add_field(v, groups_for(v) + $urandom_range(0, 1));
                v = $urandom;
                add_field(v, groups_for(v) + $urandom_range(0, 1));
                n = $urandom_range(0, 6);
                for (k = 0; k < n; k++) begin
                    repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(0, 127)));
                    msg_bytes.push_back(8'($urandom_range(128, 255)));
                end
            end else begin
                repeat ($urandom_range(0, 4)) msg_bytes.push_back(8'($urandom));
            end
        end else if (pick >= 86) begin
            repeat ($urandom_range(1, 24)) msg_bytes.push_back(8'($urandom));
        end
        blen = 16'(msg_bytes.size());
        if (pick < 70 && $urandom_range(9) == 0) blen = 16'($urandom_range(1, blen));
        send_header(blen);
        for (k = 0; k < blen; k++) send_byte(msg_bytes[k], 1'b0, '0);
    endtask

    task automatic apb_xfer(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx[0], 2'b00};
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_template(input logic [1:0] idx, input logic [15:0] val);
        logic [31:0] rd;
        apb_xfer(idx, 1'b1, {16'($urandom), val}, rd);
        if (idx == REG_TEMPLATE_FIRST) tmpl_first = val;
        else tmpl_second = val;
        apb_xfer(idx, 1'b0, 32'd0, rd);
        cmp_field("template register", rd, {16'd0, val});
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned hold_left;
        pop = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= sink_quiet || ($urandom_range(99) >= 34);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result beat expected none actual kind %0d value %0h",
                         $time, o_kind, o_value);
            end else begin
                want = pending_results.pop_front();
                cmp_field("kind", 32'(o_kind), 32'(want.kind));
                cmp_field("value", o_value, want.value);
                cmp_field("chunk_count", 32'(o_chunk_count), 32'(want.chunk_count));
                cmp_field("chunk_number", 32'(o_chunk_number), 32'(want.chunk_number));
                cmp_field("body_length", 32'(o_body_length), 32'(want.body_length));
                cmp_field("flag", 32'(o_flag), 32'(want.flag));
                cmp_field("field_number", 32'(o_field_number), 32'(want.field_number));
                cmp_field("raw_byte", 32'(o_raw_byte), 32'(want.raw_byte));
                cmp_field("last_of_field", 32'(o_last_of_field), 32'(want.last_of_field));
            end
        end
    end

    initial begin : stimulus
        t_stim_row   msg_table [$];
        logic [31:0] rd;
        logic [15:0] first_set [4];
        logic [15:0] second_set [4];
        int unsigned mark;
        int unsigned p;
        int unsigned k;

        push = 1'b0;
        i_data_byte = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apb_xfer(REG_TEMPLATE_FIRST, 1'b0, 32'd0, rd);
        cmp_field("template register", rd, 32'd144);
        apb_xfer(REG_TEMPLATE_SECOND, 1'b0, 32'd0, rd);
        cmp_field("template register", rd, 32'd145);

        // All-ones header with an empty body.
        repeat (8) msg_table.push_back('{8'hFF, 1'b0, '0});
        msg_table.push_back('{8'h00, 1'b0, '0});
        msg_table.push_back('{8'h00, 1'b1,
            mk_res(KIND_HEADER, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'd0, '0, '0, '0, '0)});
        // Known template, sequence field, one raw byte, then a field left open.
        repeat (9) msg_table.push_back('{8'h00, 1'b0, '0});
        msg_table.push_back('{8'h06, 1'b1,
            mk_res(KIND_HEADER, '0, '0, '0, 16'd6, '0, '0, '0, '0)});
        msg_table.push_back('{8'hC0, 1'b1,
            mk_res(KIND_MAP, 32'h40, '0, '0, '0, 1'b1, 16'd1, '0, '0)});
        msg_table.push_back('{8'h01, 1'b0, '0});
        msg_table.push_back('{8'h90, 1'b1,
            mk_res(KIND_TEMPLATE, 32'd144, '0, '0, '0, 1'b1, 16'd2, '0, '0)});
        msg_table.push_back('{8'hFF, 1'b0, '0});
        msg_table.push_back('{8'h80, 1'b0, '0});
        msg_table.push_back('{8'h05, 1'b0, '0});
        // Presence map without the template bit.
        repeat (9) msg_table.push_back('{8'h00, 1'b0, '0});
        msg_table.push_back('{8'h01, 1'b1,
            mk_res(KIND_HEADER, '0, '0, '0, 16'd1, '0, '0, '0, '0)});
        msg_table.push_back('{8'h80, 1'b1,
            mk_res(KIND_MAP, '0, '0, '0, '0, 1'b0, 16'd1, '0, '0)});

        foreach (msg_table[i]) send_byte(msg_table[i].data, msg_table[i].typed,
                                         msg_table[i].want);
        drain();

        first_set[0] = 16'hFFFF;
        second_set[0] = 16'h0000;
        first_set[1] = 16'h0000;
        second_set[1] = 16'h0000;
        first_set[2] = 16'($urandom_range(1, 65535));
        second_set[2] = 16'($urandom_range(1, 127));
        first_set[3] = 16'h0001;
        second_set[3] = 16'hFFFF;

        for (p = 0; p < 4; p++) begin
            set_template(REG_TEMPLATE_FIRST, first_set[p]);
            set_template(REG_TEMPLATE_SECOND, second_set[p]);
            if (p == 0) hold_req = 1'b1;
            mark = stream_bytes;
            while (stream_bytes < mark + PHASE_BYTES) send_random_message();
            if (p == 3) begin
                // Long body, one field per byte, with no idling on either side.
                src_quiet = 1'b1;
                sink_quiet = 1'b1;
                send_header(16'd200);
                send_byte(8'hC0, 1'b0, '0);
                send_byte(8'h81, 1'b0, '0);
                send_byte(8'($urandom_range(128, 255)), 1'b0, '0);
                for (k = 0; k < 197; k++) send_byte(8'($urandom_range(128, 255)), 1'b0, '0);
                src_quiet = 1'b0;
                sink_quiet = 1'b0;
                mark = stream_bytes;
                while (stream_bytes < mark + 40) send_random_message();
            end
            drain();
        end

        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
